### rtl/core/assert_macros.svh
// Assertion macros shared by the checker files of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

### rtl/core/tgc_pkg.sv
// Shared types, constants and tables of the trot gait cycloid generator.
`timescale 1ns / 1ps

package tgc_pkg;

   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 88;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   // Q16 fixed-point constants of the sine polynomial and the cycloid.
   localparam logic [16:0] Q16_ONE        = 17'd65536;
   localparam logic [16:0] SIN_A          = 17'd102944;
   localparam logic [15:0] SIN_B          = 16'd42047;
   localparam logic [12:0] SIN_C          = 13'd4640;
   localparam logic [14:0] INV_TWO_PI_Q16 = 15'd10430;

   // Register values after reset.
   localparam logic [23:0] PHASE_STEP_RESET     = 24'd1678;
   localparam logic [15:0] SUPPORT_GAIN_RESET   = 16'd2867;
   localparam logic [15:0] SWING_GAIN_RESET     = 16'd1229;
   localparam logic [15:0] SUPPORT_TORQUE_RESET = 16'd0;
   localparam logic [15:0] SWING_TORQUE_RESET   = 16'd0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PHASE_STEP     = 3'd0,
      CSR_SUPPORT_GAIN   = 3'd1,
      CSR_SWING_GAIN     = 3'd2,
      CSR_SUPPORT_TORQUE = 3'd3,
      CSR_SWING_TORQUE   = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_QUANT,
      ST_RECIP,
      ST_FRAC,
      ST_SQUARE,
      ST_POLY1,
      ST_POLY2,
      ST_SINE,
      ST_CYCLOID,
      ST_PRODUCT,
      ST_TARGET,
      ST_EMIT
   } state_type;

   // One enable per datapath step, plus the leg being emitted.
   typedef struct packed {
      logic       capture;
      logic       quantize;
      logic       recip;
      logic       frac;
      logic       square;
      logic       poly1;
      logic       poly2;
      logic       sine;
      logic       cycloid;
      logic       product;
      logic       target;
      logic       emit;
      logic [1:0] leg;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   // Per-motor gain factors in Q12, leg 0 first motor up to leg 3 second motor.
   function automatic logic [12:0] motor_factor(input logic [2:0] idx);
      logic [12:0] f;
      case (idx)
         3'd0:    f = 13'd5120;
         3'd1:    f = 13'd4710;
         3'd2:    f = 13'd5325;
         3'd3:    f = 13'd4915;
         3'd4:    f = 13'd4792;
         3'd5:    f = 13'd5407;
         3'd6:    f = 13'd5612;
         3'd7:    f = 13'd6144;
         default: f = 13'd0;
      endcase
      return f;
   endfunction

endpackage

### rtl/core/tgc_ctrl.sv
// Sequencing state machine of the trot gait cycloid generator.
`timescale 1ns / 1ps

module tgc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  tgc_pkg::status_type status,
   output tgc_pkg::cmd_type    cmd
);

   tgc_pkg::state_type state_ff, state_in;
   logic [1:0]         leg_ff, leg_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tgc_pkg::ST_IDLE;
         leg_ff   <= 2'd0;
      end else begin
         state_ff <= state_in;
         leg_ff   <= leg_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      leg_in   = leg_ff;
      case (state_ff)
         tgc_pkg::ST_IDLE: begin
            leg_in = 2'd0;
            if (req_tvalid) begin
               state_in = tgc_pkg::ST_QUANT;
            end
         end
         tgc_pkg::ST_QUANT:   state_in = tgc_pkg::ST_RECIP;
         tgc_pkg::ST_RECIP:   state_in = tgc_pkg::ST_FRAC;
         tgc_pkg::ST_FRAC:    state_in = tgc_pkg::ST_SQUARE;
         tgc_pkg::ST_SQUARE:  state_in = tgc_pkg::ST_POLY1;
         tgc_pkg::ST_POLY1:   state_in = tgc_pkg::ST_POLY2;
         tgc_pkg::ST_POLY2:   state_in = tgc_pkg::ST_SINE;
         tgc_pkg::ST_SINE:    state_in = tgc_pkg::ST_CYCLOID;
         tgc_pkg::ST_CYCLOID: state_in = tgc_pkg::ST_PRODUCT;
         tgc_pkg::ST_PRODUCT: state_in = tgc_pkg::ST_TARGET;
         tgc_pkg::ST_TARGET:  state_in = tgc_pkg::ST_EMIT;
         tgc_pkg::ST_EMIT: begin
            if (status.out_free) begin
               leg_in = leg_ff + 2'd1;
               if (leg_ff == 2'd3) begin
                  state_in = tgc_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = tgc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.leg    = leg_ff;
      req_tready = 1'b0;
      case (state_ff)
         tgc_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         tgc_pkg::ST_QUANT:   cmd.quantize = 1'b1;
         tgc_pkg::ST_RECIP:   cmd.recip    = 1'b1;
         tgc_pkg::ST_FRAC:    cmd.frac     = 1'b1;
         tgc_pkg::ST_SQUARE:  cmd.square   = 1'b1;
         tgc_pkg::ST_POLY1:   cmd.poly1    = 1'b1;
         tgc_pkg::ST_POLY2:   cmd.poly2    = 1'b1;
         tgc_pkg::ST_SINE:    cmd.sine     = 1'b1;
         tgc_pkg::ST_CYCLOID: cmd.cycloid  = 1'b1;
         tgc_pkg::ST_PRODUCT: cmd.product  = 1'b1;
         tgc_pkg::ST_TARGET:  cmd.target   = 1'b1;
         tgc_pkg::ST_EMIT:    cmd.emit     = status.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

### rtl/core/tgc_datapath.sv
// Phase, trajectory and gain datapath of the trot gait cycloid generator.
`timescale 1ns / 1ps

module tgc_datapath #(
   parameter int PHASE_BITS       = 24,
   parameter int TRIG_TABLE_DEPTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tgc_pkg::cmd_type                    cmd,
   output tgc_pkg::status_type                 status,
   input  logic [tgc_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tgc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tgc_pkg::CSR_DATA_W-1:0]      csr_data,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tgc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic [1:0]                          rsp_tuser,
   output logic                                rsp_tlast
);

   localparam int KW  = $clog2(TRIG_TABLE_DEPTH + 1);
   localparam int KPW = PHASE_BITS + 1 + KW;
   localparam logic [KW-1:0]         DEPTH_K    = KW'(TRIG_TABLE_DEPTH);
   localparam logic [22:0]           RECIP_K    = 23'((2 ** 28) / TRIG_TABLE_DEPTH);
   localparam logic [PHASE_BITS:0]   PHASE_ONE  = {1'b1, {PHASE_BITS{1'b0}}};
   localparam logic [PHASE_BITS-1:0] PHASE_HALF = {1'b1, {(PHASE_BITS-1){1'b0}}};

   function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
      logic signed [15:0] r;
      if (v > 20'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -20'sd32768) begin
         r = -16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // Quarter-wave fold: returns the negate flag and the Q16 quarter fraction.
   function automatic logic [17:0] quarter_fold(input logic [15:0] a);
      logic [16:0] x;
      x = {1'b0, a[13:0], 2'b00};
      if (a[14]) begin
         x = tgc_pkg::Q16_ONE - x;
      end
      return {a[15], x};
   endfunction

   // Configuration registers.
   logic [23:0]        phase_step_ff;
   logic [15:0]        support_gain_ff, swing_gain_ff;
   logic [15:0]        support_torque_ff, swing_torque_ff;

   // Gait state.
   logic [PHASE_BITS-1:0] gait_phase_ff, gait_phase_in;
   logic                  pattern_valid_ff;
   logic                  last_half_ff;
   logic                  first_half_ff, first_half_in;
   logic                  changed_ff, changed_in;

   // Per-tick working registers.
   logic signed [15:0] height_ff, lift_ff, stride_ff;
   logic [PHASE_BITS:0] u_ff, u_in;
   logic [KW-1:0]      k_ff, k_in;
   logic [16:0]        quo_ff, quo_in;
   logic [16:0]        f_ff, f_in;
   logic [16:0]        xs_ff, xc_ff;
   logic               neg_s_ff, neg_c_ff;
   logic [16:0]        x2s_ff, x2c_ff, x2s_in, x2c_in;
   logic [15:0]        t1s_ff, t1c_ff, t1s_in, t1c_in;
   logic [16:0]        t2s_ff, t2c_ff, t2s_in, t2c_in;
   logic signed [17:0] sn_ff, cs_ff, sn_in, cs_in;
   logic signed [18:0] cyc_ff, cyc_in;
   logic [16:0]        w_ff, w_in;
   logic signed [34:0] pxy_ff, pxy_in;
   logic signed [33:0] plw_ff, plw_in;
   logic signed [15:0] x_sw_ff, x_sp_ff, y_sw_ff, x_sw_in, x_sp_in, y_sw_in;

   // Output register.
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [tgc_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [1:0]                     rsp_leg_ff;
   logic                           rsp_last_ff;

   logic [PHASE_BITS-1:0] step;
   logic [PHASE_BITS:0]   phase_sum;
   logic [KPW-1:0]        kprod;
   logic [28:0]           qprod;
   logic [29:0]           num, qd, rem;
   logic [17:0]           fold_s, fold_c;
   logic [15:0]           f_cos;
   logic [33:0]           sq_s, sq_c;
   logic [29:0]           p1_s, p1_c;
   logic [32:0]           p2_s, p2_c;
   logic [33:0]           p3_s, p3_c;
   logic [16:0]           s_mag, c_mag;
   logic signed [33:0]    cyc_prod;
   logic signed [17:0]    cyc_term;
   logic signed [18:0]    wdiff;
   logic signed [18:0]    dx;
   logic signed [35:0]    npxy;
   logic signed [17:0]    lws;
   logic                  sup;
   logic [15:0]           base;
   logic [28:0]           g1_prod, g2_prod;
   logic [15:0]           g1, g2;
   logic [15:0]           out_x, out_y, out_torque;

   // Phase step aligned to the phase width.
   if (PHASE_BITS >= 24) begin : g_step_up
      assign step = PHASE_BITS'(phase_step_ff) << (PHASE_BITS - 24);
   end else begin : g_step_down
      assign step = PHASE_BITS'(phase_step_ff >> (24 - PHASE_BITS));
   end

   // Phase advance; reaching a full cycle restarts at zero.
   always_comb begin
      phase_sum = {1'b0, gait_phase_ff} + {1'b0, step};
      if (phase_sum[PHASE_BITS]) begin
         gait_phase_in = '0;
      end else begin
         gait_phase_in = phase_sum[PHASE_BITS-1:0];
      end
      first_half_in = (gait_phase_in <= PHASE_HALF);
      if (first_half_in) begin
         u_in = {gait_phase_in, 1'b0};
      end else begin
         u_in = {gait_phase_in, 1'b0} - PHASE_ONE;
      end
      changed_in = !pattern_valid_ff || (last_half_ff != first_half_in);
   end

   // Angle quantization: k = floor(u * depth), then f = floor(k * 65536 / depth)
   // by a reciprocal estimate that is at most one low, fixed by one compare.
   always_comb begin
      kprod  = KPW'(u_ff) * KPW'(DEPTH_K);
      k_in   = kprod[PHASE_BITS +: KW];
      qprod  = 29'(k_ff) * 29'(RECIP_K);
      quo_in = qprod[28:12];
      num    = 30'(k_ff) << 16;
      qd     = 30'(quo_ff) * 30'(DEPTH_K);
      rem    = num - qd;
      f_in   = quo_ff + 17'(rem >= 30'(DEPTH_K));
   end

   // Sine and cosine lanes of the quarter-wave polynomial.
   always_comb begin
      f_cos  = f_ff[15:0] + 16'd16384;
      fold_s = quarter_fold(f_ff[15:0]);
      fold_c = quarter_fold(f_cos);
      sq_s   = fold_s[16:0] * fold_s[16:0];
      sq_c   = fold_c[16:0] * fold_c[16:0];
      x2s_in = sq_s[32:16];
      x2c_in = sq_c[32:16];
      p1_s   = x2s_ff * tgc_pkg::SIN_C;
      p1_c   = x2c_ff * tgc_pkg::SIN_C;
      t1s_in = tgc_pkg::SIN_B - p1_s[29:16];
      t1c_in = tgc_pkg::SIN_B - p1_c[29:16];
      p2_s   = x2s_ff * t1s_ff;
      p2_c   = x2c_ff * t1c_ff;
      t2s_in = tgc_pkg::SIN_A - p2_s[32:16];
      t2c_in = tgc_pkg::SIN_A - p2_c[32:16];
      p3_s   = xs_ff * t2s_ff;
      p3_c   = xc_ff * t2c_ff;
      s_mag  = (p3_s[33:16] > 18'(tgc_pkg::Q16_ONE)) ? tgc_pkg::Q16_ONE : p3_s[32:16];
      c_mag  = (p3_c[33:16] > 18'(tgc_pkg::Q16_ONE)) ? tgc_pkg::Q16_ONE : p3_c[32:16];
      sn_in  = neg_s_ff ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
      cs_in  = neg_c_ff ? -$signed({1'b0, c_mag}) : $signed({1'b0, c_mag});
   end

   // Cycloid, lift profile and foot targets.
   always_comb begin
      cyc_prod = 34'(sn_ff) * 34'($signed({1'b0, tgc_pkg::INV_TWO_PI_Q16}));
      cyc_term = $signed(cyc_prod[33:16]);
      cyc_in   = $signed({2'b00, f_ff}) - 19'(cyc_term);
      wdiff    = 19'sd65536 - 19'(cs_ff);
      w_in     = wdiff[17:1];
      dx       = cyc_ff - 19'sd32768;
      pxy_in   = 35'(stride_ff) * 35'(dx);
      plw_in   = 34'(lift_ff) * 34'($signed({1'b0, w_ff}));
      npxy     = -36'(pxy_ff);
      lws      = $signed(plw_ff[33:16]);
      x_sw_in  = sat16(20'($signed(pxy_ff[34:16])));
      x_sp_in  = sat16($signed(npxy[35:16]));
      y_sw_in  = sat16(20'(height_ff) - 20'(lws));
   end

   // Result of the leg being emitted. Legs whose parity matches the half
   // cycle flag are the support legs.
   always_comb begin
      sup        = (cmd.leg[0] == first_half_ff);
      base       = sup ? support_gain_ff : swing_gain_ff;
      g1_prod    = 29'(base) * 29'(tgc_pkg::motor_factor({cmd.leg, 1'b0}));
      g2_prod    = 29'(base) * 29'(tgc_pkg::motor_factor({cmd.leg, 1'b1}));
      g1         = g1_prod[28] ? 16'hffff : g1_prod[27:12];
      g2         = g2_prod[28] ? 16'hffff : g2_prod[27:12];
      out_x      = sup ? x_sp_ff : x_sw_ff;
      out_y      = sup ? height_ff : y_sw_ff;
      out_torque = sup ? support_torque_ff : swing_torque_ff;
      rsp_data_in = {6'b000000, changed_ff, out_torque, g2, g1, sup, out_y, out_x};
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff     <= tgc_pkg::PHASE_STEP_RESET;
         support_gain_ff   <= tgc_pkg::SUPPORT_GAIN_RESET;
         swing_gain_ff     <= tgc_pkg::SWING_GAIN_RESET;
         support_torque_ff <= tgc_pkg::SUPPORT_TORQUE_RESET;
         swing_torque_ff   <= tgc_pkg::SWING_TORQUE_RESET;
      end else if (csr_valid) begin
         case (tgc_pkg::csr_index_type'(csr_index))
            tgc_pkg::CSR_PHASE_STEP:     phase_step_ff     <= csr_data;
            tgc_pkg::CSR_SUPPORT_GAIN:   support_gain_ff   <= csr_data[15:0];
            tgc_pkg::CSR_SWING_GAIN:     swing_gain_ff     <= csr_data[15:0];
            tgc_pkg::CSR_SUPPORT_TORQUE: support_torque_ff <= csr_data[15:0];
            tgc_pkg::CSR_SWING_TORQUE:   swing_torque_ff   <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gait_phase_ff    <= '0;
         pattern_valid_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (cmd.capture) begin
            gait_phase_ff    <= gait_phase_in;
            pattern_valid_ff <= 1'b1;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         height_ff     <= $signed(req_tdata[15:0]);
         lift_ff       <= $signed(req_tdata[31:16]);
         stride_ff     <= $signed(req_tdata[47:32]);
         u_ff          <= u_in;
         first_half_ff <= first_half_in;
         last_half_ff  <= first_half_in;
         changed_ff    <= changed_in;
      end
      if (cmd.quantize) begin
         k_ff <= k_in;
      end
      if (cmd.recip) begin
         quo_ff <= quo_in;
      end
      if (cmd.frac) begin
         f_ff <= f_in;
      end
      if (cmd.square) begin
         xs_ff    <= fold_s[16:0];
         xc_ff    <= fold_c[16:0];
         neg_s_ff <= fold_s[17];
         neg_c_ff <= fold_c[17];
         x2s_ff   <= x2s_in;
         x2c_ff   <= x2c_in;
      end
      if (cmd.poly1) begin
         t1s_ff <= t1s_in;
         t1c_ff <= t1c_in;
      end
      if (cmd.poly2) begin
         t2s_ff <= t2s_in;
         t2c_ff <= t2c_in;
      end
      if (cmd.sine) begin
         sn_ff <= sn_in;
         cs_ff <= cs_in;
      end
      if (cmd.cycloid) begin
         cyc_ff <= cyc_in;
         w_ff   <= w_in;
      end
      if (cmd.product) begin
         pxy_ff <= pxy_in;
         plw_ff <= plw_in;
      end
      if (cmd.target) begin
         x_sw_ff <= x_sw_in;
         x_sp_ff <= x_sp_in;
         y_sw_ff <= y_sw_in;
      end
      if (cmd.emit) begin
         rsp_data_ff <= rsp_data_in;
         rsp_leg_ff  <= cmd.leg;
         rsp_last_ff <= (cmd.leg == 2'd3);
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign csr_ready       = 1'b1;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;
   assign rsp_tuser       = rsp_leg_ff;
   assign rsp_tlast       = rsp_last_ff;

endmodule

### rtl/core/trot_gait_cycloid_generator.sv
// Top level of the trot gait cycloid generator.
`timescale 1ns / 1ps
// Trot gait foot trajectory generator, four leg results per control tick.
// The req channel carries one tick (stand height, lift height, step length).
// For each accepted tick the block advances the gait phase and sends four
// transfers on the rsp channel, legs 0 to 3 in order, with tlast on leg 3.
// The csr channel writes the registers (phase step, gains, torques) by index;
// it is always ready and is meant to be written while the block is idle.
// The controller walks the datapath through ten steps (quantize, reciprocal,
// fraction fix, square, two polynomial steps, sine, cycloid, product, target),
// then emits one leg per cycle whenever the output register is free.
// The sequencer accepts a new tick only after all four legs are loaded out.
// A stalled receiver holds the output register and the controller in place;
// the next request is taken while the last leg still waits in the register.
// Reset clears the phase, the pattern history and the output valid, and
// restores the register defaults; the first tick after reset is flagged as a
// pattern change.
module trot_gait_cycloid_generator #(
   parameter int PHASE_BITS       = 24,
   parameter int TRIG_TABLE_DEPTH = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   // stand_height[15:0], lift_height[31:16], step_length[47:32]
   input  logic [tgc_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // foot_x[15:0], foot_y[31:16], in_support[32], gain_first_motor[48:33],
   // gain_second_motor[64:49], leg_torque[80:65], pattern_changed[81], zeros above
   output logic [tgc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // leg[1:0]
   output logic [1:0]                      rsp_tuser,
   output logic                            rsp_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [tgc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tgc_pkg::CSR_DATA_W-1:0]  csr_data
);

   tgc_pkg::cmd_type    cmd;
   tgc_pkg::status_type status;

   tgc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tgc_datapath #(
      .PHASE_BITS       (PHASE_BITS),
      .TRIG_TABLE_DEPTH (TRIG_TABLE_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### rtl/core/tgc_checker.sv
// Port-level assertion checker of the trot gait cycloid generator, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tgc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [tgc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [1:0]                     rsp_tuser,
   input logic                           rsp_tlast
);

   // A stalled result stays offered.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)

   // A stalled result keeps its payload.
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))

   // Only the fourth leg of a tick carries tlast.
   `ASSERT_IMPLIES(a_last_is_leg3, clock, reset, rsp_tvalid, rsp_tlast == (rsp_tuser == 2'd3))

   // Legs of one tick follow each other without a gap.
   `ASSERT_NEXT(a_leg_order, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tvalid && (rsp_tuser == $past(rsp_tuser) + 2'd1))

   // A new tick is taken only once the previous one is down to its last leg.
   `ASSERT_IMPLIES(a_accept_after_tick, clock, reset, req_tvalid && req_tready && rsp_tvalid, rsp_tlast)

endmodule

bind trot_gait_cycloid_generator tgc_checker u_tgc_checker (.*);

### tb/tb.sv
// Self-checking testbench of the trot gait cycloid generator: predicted leg results vs. RTL.
`timescale 1ns / 1ps

// One leg result as it travels on the rsp channel.
typedef struct {
   logic [1:0]         leg;
   logic signed [15:0] foot_x;
   logic signed [15:0] foot_y;
   logic               in_support;
   logic [15:0]        gain_first_motor;
   logic [15:0]        gain_second_motor;
   logic signed [15:0] leg_torque;
   logic               pattern_changed;
   logic               last_leg;
} leg_result_type;

class gait_scoreboard;
   localparam int     PHASE_W     = 24;
   localparam int     TRIG_DEPTH  = 1024;
   localparam longint FULL_CYCLE  = 64'sd16777216;
   localparam longint TURN_Q16    = 65536;
   localparam longint POLY_A      = 102944;
   localparam longint POLY_B      = 42047;
   localparam longint POLY_C      = 4640;
   localparam longint INV_TWO_PI  = 10430;
   localparam logic [23:0] HALF_CYCLE = 24'h800000;
   // Bit i set means leg i supports.
   localparam logic [3:0] PATTERN_FIRST_HALF  = 4'b1010;
   localparam logic [3:0] PATTERN_SECOND_HALF = 4'b0101;
   localparam longint MOTOR_FACTOR [8] = '{5120, 4710, 5325, 4915, 4792, 5407, 5612, 6144};

   logic [23:0] phase_step;
   logic [15:0] support_gain;
   logic [15:0] swing_gain;
   logic [15:0] support_torque;
   logic [15:0] swing_torque;
   logic [23:0] gait_phase;
   logic [3:0]  last_pattern;
   bit          pattern_valid;
   leg_result_type expected_legs[$];
   int          errors;

   function new();
      phase_step     = tgc_pkg::PHASE_STEP_RESET;
      support_gain   = tgc_pkg::SUPPORT_GAIN_RESET;
      swing_gain     = tgc_pkg::SWING_GAIN_RESET;
      support_torque = tgc_pkg::SUPPORT_TORQUE_RESET;
      swing_torque   = tgc_pkg::SWING_TORQUE_RESET;
      gait_phase     = '0;
      last_pattern   = '0;
      pattern_valid  = 1'b0;
      errors         = 0;
   endfunction

   function void write_reg(logic [2:0] idx, logic [23:0] value);
      case (idx)
         tgc_pkg::CSR_PHASE_STEP:     phase_step     = value;
         tgc_pkg::CSR_SUPPORT_GAIN:   support_gain   = value[15:0];
         tgc_pkg::CSR_SWING_GAIN:     swing_gain     = value[15:0];
         tgc_pkg::CSR_SUPPORT_TORQUE: support_torque = value[15:0];
         tgc_pkg::CSR_SWING_TORQUE:   swing_torque   = value[15:0];
         default: ;
      endcase
   endfunction

   function longint sat16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // Polynomial sine over one quarter turn, argument and result in Q16.
   function longint quarter_sine(longint x);
      longint x2, t, s;
      x2 = (x * x) >>> 16;
      t = POLY_B - ((x2 * POLY_C) >>> 16);
      t = POLY_A - ((x2 * t) >>> 16);
      s = (x * t) >>> 16;
      if (s > TURN_Q16) s = TURN_Q16;
      return s;
   endfunction

   function longint turn_sine(longint f);
      longint q, x, s;
      f = f & 65535;
      q = f >> 14;
      x = (f & 16383) << 2;
      if (q[0]) x = TURN_Q16 - x;
      s = quarter_sine(x);
      return (q >= 2) ? -s : s;
   endfunction

   function void note_tick(logic signed [15:0] height, logic signed [15:0] lift,
                           logic signed [15:0] stride);
      logic [24:0] sum;
      logic        first_half;
      logic [3:0]  pattern;
      bit          changed;
      bit          sup;
      longint      u, k, turn, sn, cs, cyc, w;
      longint      x_swing, x_support, y_swing, base, g1, g2;
      leg_result_type r;
      sum = {1'b0, gait_phase} + {1'b0, phase_step};
      // Reaching a full cycle restarts at zero; the remainder is dropped.
      gait_phase = sum[24] ? '0 : sum[23:0];
      first_half = (gait_phase <= HALF_CYCLE);
      u = first_half ? 2 * longint'(gait_phase) : 2 * longint'(gait_phase) - FULL_CYCLE;
      k = (u * TRIG_DEPTH) >>> PHASE_W;
      turn = (k * TURN_Q16) / TRIG_DEPTH;
      sn = turn_sine(turn);
      cs = turn_sine(turn + 16384);
      cyc = turn - ((sn * INV_TWO_PI) >>> 16);
      w = (TURN_Q16 - cs) / 2;
      x_swing   = sat16((longint'(stride) * (cyc - 32768)) >>> 16);
      x_support = sat16((longint'(stride) * (32768 - cyc)) >>> 16);
      y_swing   = sat16(longint'(height) - ((longint'(lift) * w) >>> 16));
      pattern = first_half ? PATTERN_FIRST_HALF : PATTERN_SECOND_HALF;
      changed = !pattern_valid || (last_pattern != pattern);
      last_pattern = pattern;
      pattern_valid = 1'b1;
      for (int leg = 0; leg < 4; leg++) begin
         sup = pattern[leg];
         base = sup ? longint'(support_gain) : longint'(swing_gain);
         g1 = (base * MOTOR_FACTOR[2 * leg]) >>> 12;
         g2 = (base * MOTOR_FACTOR[2 * leg + 1]) >>> 12;
         if (g1 > 65535) g1 = 65535;
         if (g2 > 65535) g2 = 65535;
         r.leg               = leg[1:0];
         r.foot_x            = sup ? x_support[15:0] : x_swing[15:0];
         r.foot_y            = sup ? height : y_swing[15:0];
         r.in_support        = sup;
         r.gain_first_motor  = g1[15:0];
         r.gain_second_motor = g2[15:0];
         r.leg_torque        = sup ? support_torque : swing_torque;
         r.pattern_changed   = changed;
         r.last_leg          = (leg == 3);
         expected_legs.push_back(r);
      end
   endfunction

   function void compare_field(string name, logic [15:0] exp, logic [15:0] act);
      if (act !== exp) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, exp, act);
         errors++;
      end
   endfunction

   function void check_leg(logic [tgc_pkg::RSP_DATA_W-1:0] data, logic [1:0] user,
                           logic last_bit);
      leg_result_type e;
      if (expected_legs.size() == 0) begin
         $error("rsp transfer with no leg result expected");
         errors++;
         return;
      end
      e = expected_legs.pop_front();
      compare_field("leg", e.leg, user);
      compare_field("foot_x", e.foot_x, data[15:0]);
      compare_field("foot_y", e.foot_y, data[31:16]);
      compare_field("in_support", e.in_support, data[32]);
      compare_field("gain_first_motor", e.gain_first_motor, data[48:33]);
      compare_field("gain_second_motor", e.gain_second_motor, data[64:49]);
      compare_field("leg_torque", e.leg_torque, data[80:65]);
      compare_field("pattern_changed", e.pattern_changed, data[81]);
      compare_field("last_leg", e.last_leg, last_bit);
   endfunction
endclass

module tb;
   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic [tgc_pkg::REQ_DATA_W-1:0]  req_tdata = '0;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [tgc_pkg::RSP_DATA_W-1:0]  rsp_tdata;
   logic [1:0]                      rsp_tuser;
   logic                            rsp_tlast;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b1;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [tgc_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [tgc_pkg::CSR_DATA_W-1:0]  csr_data = '0;

   int req_idle_pct = 0;
   int rsp_stall_pct = 0;

   gait_scoreboard sb = new();

   trot_gait_cycloid_generator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Signals only change at rising edges, so the falling edge sees what the next
   // rising edge will take.
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_leg(rsp_tdata, rsp_tuser, rsp_tlast);
         if (req_tvalid && req_tready)
            sb.note_tick(req_tdata[15:0], req_tdata[31:16], req_tdata[47:32]);
      end
   end

   function automatic logic [tgc_pkg::REQ_DATA_W-1:0] pack_tick(logic [15:0] height,
                                                                logic [15:0] lift,
                                                                logic [15:0] stride);
      return {stride, lift, height};
   endfunction

   function automatic logic [15:0] rand_q88();
      case ($urandom_range(0, 9))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [23:0] rand_step();
      if ($urandom_range(0, 3) == 0) return 24'($urandom);
      return 24'($urandom_range(1, 40000));
   endfunction

   // Called at a rising edge; returns at the edge of the transfer.
   task automatic send_tick(logic [tgc_pkg::REQ_DATA_W-1:0] data);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
   endtask

   // Leaves csr_valid high; the caller lowers it after the last write.
   task automatic write_csr(logic [tgc_pkg::CSR_INDEX_W-1:0] idx,
                            logic [tgc_pkg::CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      sb.write_reg(idx, value);
      @(posedge clock);
   endtask

   task automatic write_settings(logic [23:0] step, logic [15:0] sup_gain, logic [15:0] sw_gain,
                                 logic [15:0] sup_torque, logic [15:0] sw_torque);
      write_csr(tgc_pkg::CSR_PHASE_STEP, step);
      write_csr(tgc_pkg::CSR_SUPPORT_GAIN, {8'h00, sup_gain});
      write_csr(tgc_pkg::CSR_SWING_GAIN, {8'h00, sw_gain});
      write_csr(tgc_pkg::CSR_SUPPORT_TORQUE, {8'h00, sup_torque});
      write_csr(tgc_pkg::CSR_SWING_TORQUE, {8'h00, sw_torque});
      csr_valid <= 1'b0;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (sb.expected_legs.size() != 0) @(posedge clock);
   endtask

   initial begin
      logic [tgc_pkg::CSR_INDEX_W-1:0] idx;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default settings; the first tick must be flagged as a pattern change.
      send_tick(pack_tick(16'h0000, 16'h0000, 16'h0000));
      send_tick(pack_tick(16'h7FFF, 16'h7FFF, 16'h7FFF));
      send_tick(pack_tick(16'h8000, 16'h8000, 16'h8000));
      send_tick(pack_tick(16'h7FFF, 16'h8000, 16'h7FFF));
      send_tick(pack_tick(16'h8000, 16'h7FFF, 16'h8000));
      send_tick(pack_tick(16'h5555, 16'hAAAA, 16'h1234));
      drain_results();

      // A zero step holds the phase, so the results repeat.
      write_csr(tgc_pkg::CSR_PHASE_STEP, 24'h000000);
      csr_valid <= 1'b0;
      send_tick(pack_tick(16'h1200, 16'h0400, 16'h0800));
      send_tick(pack_tick(16'h1200, 16'h0400, 16'h0800));
      drain_results();

      // A half-cycle step settles on zero and exactly one half in turn.
      write_csr(tgc_pkg::CSR_PHASE_STEP, 24'h800000);
      csr_valid <= 1'b0;
      repeat (4) send_tick(pack_tick(16'h7FFF, 16'h8000, 16'h8000));
      drain_results();

      write_csr(tgc_pkg::CSR_PHASE_STEP, 24'hFFFFFF);
      csr_valid <= 1'b0;
      repeat (3) send_tick(pack_tick(rand_q88(), rand_q88(), rand_q88()));
      drain_results();

      // Saturating gains, extreme torques, and writes to unused indexes.
      write_settings(24'h400000, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF);
      for (int i = tgc_pkg::CSR_SWING_TORQUE + 1; i < 8; i++) begin
         idx = i[tgc_pkg::CSR_INDEX_W-1:0];
         write_csr(idx, 24'hFFFFFF);
      end
      csr_valid <= 1'b0;
      send_tick(pack_tick(16'h7FFF, 16'h8000, 16'h7FFF));
      send_tick(pack_tick(16'h8000, 16'h7FFF, 16'h8000));
      send_tick(pack_tick(16'h7FFF, 16'h7FFF, 16'h8000));
      send_tick(pack_tick(16'h8000, 16'h8000, 16'h7FFF));
      drain_results();

      write_settings(24'h0A0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      repeat (3) send_tick(pack_tick(rand_q88(), rand_q88(), rand_q88()));
      drain_results();

      // Random ticks under changing settings and handshake pressure.
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               req_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               req_idle_pct = 58;
               rsp_stall_pct = 0;
            end
            2: begin
               req_idle_pct = 0;
               rsp_stall_pct = 58;
            end
            default: begin
               req_idle_pct = 17;
               rsp_stall_pct = 17;
            end
         endcase
         for (int seg = 0; seg < 2; seg++) begin
            write_settings(rand_step(), 16'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom));
            repeat (25) send_tick(pack_tick(rand_q88(), rand_q88(), rand_q88()));
            drain_results();
         end
      end

      repeat (20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end
endmodule
